FILE: sv/assert_macros.svh
// Assertion macros shared by the expander RTL.
// Expects clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/ppe_pkg.sv
// Types, register codes and helper functions of the packed pixel palette expander.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ppe_pkg;

  localparam int CFG_AW = 5;
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic KIND_PALETTE = 1'b0;
  localparam logic KIND_PIXEL   = 1'b1;

  typedef enum logic [2:0] {
    REG_FB_WIDTH        = 3'd0,
    REG_ORIGIN_X        = 3'd1,
    REG_ORIGIN_Y        = 3'd2,
    REG_RECT_WIDTH      = 3'd3,
    REG_RECT_HEIGHT     = 3'd4,
    REG_PIX_DEPTH       = 3'd5,
    REG_ROW_START_SHIFT = 3'd6,
    REG_BYTES_PER_ROW   = 3'd7
  } ppe_reg_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  palette_index;
    logic [15:0] palette_color;
    logic [7:0]  pixel_byte;
  } ppe_in_t;

  typedef struct packed {
    logic [19:0] fb_address;
    logic [15:0] pixel_color;
    logic        last_pixel;
  } ppe_out_t;

  typedef struct packed {
    logic [10:0] fb_width;
    logic [9:0]  origin_x;
    logic [9:0]  origin_y;
    logic [10:0] rect_width;
    logic [10:0] rect_height;
    logic [3:0]  pix_depth;
    logic [2:0]  row_start_shift;
    logic [10:0] bytes_per_row;
  } ppe_cfg_t;

  // one queued command: palette write or classified pixel byte
  typedef struct packed {
    logic        kind;
    logic [7:0]  pal_index;
    logic [15:0] pal_color;
    logic [7:0]  data;
    logic [2:0]  shift;
    logic [3:0]  count;
    logic [10:0] col;
    logic [10:0] row;
    logic        last_row;
  } ppe_cmd_t;

  function automatic logic [3:0] clamp_bpp(input logic [3:0] v);
    if (v == 4'd0) return 4'd1;
    if (v > 4'd8) return 4'd8;
    return v;
  endfunction

  function automatic logic [10:0] clamp_bpr(input logic [10:0] v);
    if (v == 11'd0) return 11'd1;
    if (v > 11'd1024) return 11'd1024;
    return v;
  endfunction

  // pixels in a byte starting at shift: shift / bpp + 1
  function automatic logic [3:0] pix_count(input logic [2:0] shift, input logic [3:0] bpp);
    logic [3:0] n;
    n = 4'd1;
    for (int k = 1; k < 8; k++) begin
      if (6'(k) * {2'b00, bpp} <= {3'b000, shift}) n = n + 4'd1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: sv/ppe_regs.sv
// APB-style configuration register file of the expander.
// Depends on ppe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppe_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ppe_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output ppe_pkg::ppe_cfg_t          cfg,
  output logic                       cfg_wr
);
  import ppe_pkg::*;

  ppe_cfg_t cfg_r, cfg_nxt;
  ppe_reg_e idx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign idx    = ppe_reg_e'(paddr[CFG_AW-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (idx)
        REG_FB_WIDTH:        cfg_nxt.fb_width        = pwdata[10:0];
        REG_ORIGIN_X:        cfg_nxt.origin_x        = pwdata[9:0];
        REG_ORIGIN_Y:        cfg_nxt.origin_y        = pwdata[9:0];
        REG_RECT_WIDTH:      cfg_nxt.rect_width      = pwdata[10:0];
        REG_RECT_HEIGHT:     cfg_nxt.rect_height     = pwdata[10:0];
        REG_PIX_DEPTH:       cfg_nxt.pix_depth       = pwdata[3:0];
        REG_ROW_START_SHIFT: cfg_nxt.row_start_shift = pwdata[2:0];
        REG_BYTES_PER_ROW:   cfg_nxt.bytes_per_row   = pwdata[10:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FB_WIDTH:        prdata = 32'(cfg_r.fb_width);
      REG_ORIGIN_X:        prdata = 32'(cfg_r.origin_x);
      REG_ORIGIN_Y:        prdata = 32'(cfg_r.origin_y);
      REG_RECT_WIDTH:      prdata = 32'(cfg_r.rect_width);
      REG_RECT_HEIGHT:     prdata = 32'(cfg_r.rect_height);
      REG_PIX_DEPTH:       prdata = 32'(cfg_r.pix_depth);
      REG_ROW_START_SHIFT: prdata = 32'(cfg_r.row_start_shift);
      REG_BYTES_PER_ROW:   prdata = 32'(cfg_r.bytes_per_row);
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fb_width        <= 11'd320;
      cfg_r.origin_x        <= 10'd0;
      cfg_r.origin_y        <= 10'd0;
      cfg_r.rect_width      <= 11'd0;
      cfg_r.rect_height     <= 11'd0;
      cfg_r.pix_depth       <= 4'd1;
      cfg_r.row_start_shift <= 3'd7;
      cfg_r.bytes_per_row   <= 11'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ppe_front.sv
// Front end: accepts input transfers, tracks row/column/byte position and
// classifies each byte into a command for the queue. Depends on ppe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  ppe_pkg::ppe_cfg_t cfg,
  input  logic              cfg_wr,
  input  logic              in_valid,
  output logic              in_stall,
  input  ppe_pkg::ppe_in_t  in_data,
  input  logic              q_full,
  output logic              q_push,
  output ppe_pkg::ppe_cmd_t q_cmd
);
  import ppe_pkg::*;

  logic [10:0] row_r, row_nxt;
  logic [10:0] col_r, col_nxt;
  logic [9:0]  byte_r, byte_nxt;

  logic [3:0]  bpp;
  logic [10:0] bpr;
  logic [2:0]  shift0;
  logic [3:0]  npix;
  logic        in_rect;
  logic [10:0] avail;
  logic [3:0]  emit;
  logic        row_end;
  logic [11:0] row_inc;
  logic        is_pixel;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign is_pixel = in_data.kind == KIND_PIXEL;

  assign bpp     = clamp_bpp(cfg.pix_depth);
  assign bpr     = clamp_bpr(cfg.bytes_per_row);
  assign shift0  = (byte_r == 10'd0) ? cfg.row_start_shift : 3'(4'd8 - bpp);
  assign npix    = pix_count(shift0, bpp);
  assign in_rect = row_r < cfg.rect_height;
  assign avail   = cfg.rect_width - col_r;
  assign emit    = !in_rect ? 4'd0 : ((avail < 11'(npix)) ? avail[3:0] : npix);
  assign row_end = ({1'b0, byte_r} + 11'd1) >= bpr;
  assign row_inc = {1'b0, row_r} + 12'd1;

  always_comb begin
    q_cmd.kind      = in_data.kind;
    q_cmd.pal_index = in_data.palette_index;
    q_cmd.pal_color = in_data.palette_color;
    q_cmd.data      = in_data.pixel_byte;
    q_cmd.shift     = shift0;
    q_cmd.count     = emit;
    q_cmd.col       = col_r;
    q_cmd.row       = row_r;
    q_cmd.last_row  = row_inc == {1'b0, cfg.rect_height};
  end

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    byte_nxt = byte_r;
    if (cfg_wr) begin
      row_nxt  = 11'd0;
      col_nxt  = 11'd0;
      byte_nxt = 10'd0;
    end else if (q_push && is_pixel) begin
      if (row_end) begin
        byte_nxt = 10'd0;
        col_nxt  = 11'd0;
        row_nxt  = (row_inc >= {1'b0, cfg.rect_height}) ? 11'd0 : row_inc[10:0];
      end else begin
        byte_nxt = byte_r + 10'd1;
        col_nxt  = col_r + 11'(emit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= 11'd0;
      col_r  <= 11'd0;
      byte_r <= 10'd0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      byte_r <= byte_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ppe_fifo.sv
// Short command queue between front and back end.
// Depends on ppe_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ppe_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ppe_pkg::ppe_cmd_t cmd_in,
  output logic              full,
  input  logic              pop,
  output ppe_pkg::ppe_cmd_t cmd_out,
  output logic              not_empty
);
  import ppe_pkg::*;

  ppe_cmd_t       slot_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_pop;

  assign full      = cnt_r == (QAW+1)'(QDEPTH);
  assign not_empty = cnt_r != '0;
  assign cmd_out   = slot_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= cmd_in;
  end

  `ASSERT_ALWAYS(a_no_overfill, cnt_r <= (QAW+1)'(QDEPTH), "queue count above depth")
  `ASSERT_IMPLIES(a_no_push_full, full, !push, "transfer pushed into full queue")

endmodule

`default_nettype wire

FILE: sv/ppe_back.sv
// Back end: palette memory, per-byte pixel emitter and output register.
// Depends on ppe_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ppe_back #(
  parameter int PALETTE_DEPTH = 256,
  parameter int MAX_FB_WIDTH  = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ppe_pkg::ppe_cfg_t cfg,
  input  logic              q_valid,
  input  ppe_pkg::ppe_cmd_t q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output ppe_pkg::ppe_out_t out_data
);
  import ppe_pkg::*;

  localparam int          PAL_AW  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [8:0]  PAL_LIM = 9'(PALETTE_DEPTH);
  localparam logic [12:0] MAXW    = 13'(MAX_FB_WIDTH);

  logic [15:0] pal_mem_r [PALETTE_DEPTH];

  logic        d_valid_r;
  logic [7:0]  d_data_r;
  logic [2:0]  d_shift_r;
  logic [3:0]  d_left_r;
  logic [10:0] d_col_r;
  logic        d_last_row_r;
  logic [19:0] d_base_r;

  logic        out_valid_r;
  logic [19:0] addr_r;
  logic [15:0] rd_color_r;
  logic        last_r;
  logic        oor_r;

  logic [3:0]  bpp;
  logic [10:0] stride;
  logic [11:0] row_sum;
  logic [22:0] prod;
  logic [7:0]  pix_mask;
  logic [7:0]  pix_idx;
  logic [19:0] addr;
  logic        last;
  logic        issue;
  logic        d_done;
  logic        load;
  logic        pal_we;

  assign bpp      = clamp_bpp(cfg.pix_depth);
  assign stride   = ({2'b00, cfg.fb_width} > MAXW) ? MAXW[10:0] : cfg.fb_width;
  assign row_sum  = {2'b00, cfg.origin_y} + {1'b0, q_cmd.row};
  assign prod     = {11'd0, row_sum} * {12'd0, stride};
  assign pix_mask = 8'((9'd1 << bpp) - 9'd1);
  assign pix_idx  = 8'(d_data_r >> d_shift_r) & pix_mask;
  assign addr     = d_base_r + 20'(cfg.origin_x) + 20'(d_col_r);
  assign last     = d_last_row_r && (({1'b0, d_col_r} + 12'd1) == {1'b0, cfg.rect_width});

  assign issue  = d_valid_r && (!out_valid_r || !out_stall);
  assign d_done = !d_valid_r || (issue && d_left_r == 4'd1);
  assign q_pop  = q_valid && d_done;
  assign load   = q_pop && q_cmd.kind == KIND_PIXEL && q_cmd.count != 4'd0;
  assign pal_we = q_pop && q_cmd.kind == KIND_PALETTE && ({1'b0, q_cmd.pal_index} < PAL_LIM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (load) begin
      d_valid_r <= 1'b1;
    end else if (d_done) begin
      d_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d_data_r     <= q_cmd.data;
      d_shift_r    <= q_cmd.shift;
      d_left_r     <= q_cmd.count;
      d_col_r      <= q_cmd.col;
      d_last_row_r <= q_cmd.last_row;
      d_base_r     <= prod[19:0];
    end else if (issue) begin
      d_shift_r <= d_shift_r - bpp[2:0];
      d_left_r  <= d_left_r - 4'd1;
      d_col_r   <= d_col_r + 11'd1;
    end
  end

  // palette write and registered lookup
  always_ff @(posedge clk) begin
    if (pal_we) pal_mem_r[q_cmd.pal_index[PAL_AW-1:0]] <= q_cmd.pal_color;
    if (issue) rd_color_r <= pal_mem_r[pix_idx[PAL_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (issue) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      addr_r <= addr;
      last_r <= last;
      oor_r  <= {1'b0, pix_idx} >= PAL_LIM;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_data.fb_address  = addr_r;
  assign out_data.pixel_color = oor_r ? 16'd0 : rd_color_r;
  assign out_data.last_pixel  = last_r;

  `ASSERT_IMPLIES(a_left_nonzero, d_valid_r, d_left_r != 4'd0, "emitter busy with no pixels left")
  `ASSERT_IMPLIES(a_pop_on_finish, q_pop && d_valid_r, issue && d_left_r == 4'd1,
                  "queue popped while emitter mid-byte")
  `ASSERT_IMPLIES(a_issue_blocked, out_valid_r && out_stall, !issue,
                  "pixel issued into stalled output register")

endmodule

`default_nettype wire

FILE: sv/packed_pixel_palette_expander.sv
// A byte's first result passes the command queue, emitter and output register in that order.
// Throughput: one result per cycle while out_stall is low. A byte holds the emitter until
// it issues all its pixels (up to 8); palette writes and empty bytes never load it. The front
// accepts one transfer per cycle while the four-entry command queue has room.
// Reset: synchronous; counters and registers to defaults, palette contents undefined.
`timescale 1ns / 1ps
`default_nettype none

module packed_pixel_palette_expander #(
  parameter int PALETTE_DEPTH = 256,
  parameter int MAX_FB_WIDTH  = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ppe_pkg::ppe_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ppe_pkg::ppe_out_t          out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ppe_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import ppe_pkg::*;

  ppe_cfg_t cfg;
  logic     cfg_wr;
  logic     q_full;
  logic     q_push;
  ppe_cmd_t q_in;
  logic     q_pop;
  ppe_cmd_t q_out;
  logic     q_valid;

  ppe_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  ppe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .cfg_wr   (cfg_wr),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_in)
  );

  ppe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .cmd_in    (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .cmd_out   (q_out),
    .not_empty (q_valid)
  );

  ppe_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .MAX_FB_WIDTH  (MAX_FB_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_cmd     (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
